FILE: src/ttsd_pkg.sv
`default_nettype none

package ttsd_pkg;

    typedef enum logic [1:0] {
        MODE_DRAFT9  = 2'd0,
        MODE_RFC5766 = 2'd1,
        MODE_PREFIX  = 2'd2,
        MODE_RSVD    = 2'd3
    } frame_mode_t;

    localparam frame_mode_t MODE_RESET = MODE_RFC5766;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_FRAME_MODE = 3'd0;

    localparam int HDR_W  = 16;
    localparam int LEFT_W = 17;

    localparam logic [HDR_W-1:0]  STUN_LIMIT = 16'h4000;
    localparam logic [LEFT_W-1:0] STUN_BASE  = 17'd20;
    localparam logic [LEFT_W-1:0] CD_BASE    = 17'd4;
    localparam logic [LEFT_W-1:0] PAD_ADD    = 17'd3;
    localparam logic [LEFT_W-1:0] PAD_MASK   = ~17'd3;
    localparam logic [LEFT_W-1:0] HDR_BYTES  = 17'd4;

    typedef enum logic [1:0] {
        HC_0 = 2'd0,
        HC_1 = 2'd1,
        HC_2 = 2'd2,
        HC_3 = 2'd3
    } hdr_count_t;

endpackage

`default_nettype wire

FILE: src/turn_tcp_stream_deframer_top.sv
// Each result is registered in the output register, or in the skid if that stalls.
// Throughput: one byte per clock while in_stall is low; the frame state updates in a
// single pass per byte. A two-entry output stage (result register plus skid) keeps
// input flowing while the output stalls; in_stall rises only when the skid is full.
// Reset (rst_n low, async): frame state cleared, frame_mode = rfc5766, outputs empty.
`default_nettype none

module turn_tcp_stream_deframer_top
    import ttsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready,

    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [7:0]         data_byte,

    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [7:0]         out_byte,
    output      logic               frame_first,
    output      logic               frame_last
);

    frame_mode_t       frame_mode_reg;
    logic [HDR_W-1:0]  header_word_reg,  header_word_next;
    hdr_count_t        header_count_reg, header_count_next;
    logic [LEFT_W-1:0] bytes_left_reg,   bytes_left_next;
    logic              in_body_reg,      in_body_next;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_first_reg, out_last_reg;
    logic              skid_valid_reg;
    logic [7:0]        skid_byte_reg;
    logic              skid_first_reg, skid_last_reg;

    logic              res_valid, res_first, res_last;
    logic              in_fire, out_fire, cfg_wr, reg_hit;
    logic [LEFT_W-1:0] left_dec, hdr_sum, hdr_padded;
    logic [HDR_W-1:0]  prefix_len;

    // config port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_FRAME_MODE[PADDR_W-1]);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign prdata  = reg_hit ? {{(PDATA_W-2){1'b0}}, frame_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= MODE_RESET;
        end
        else if (cfg_wr)
        begin
            frame_mode_reg <= frame_mode_t'(pwdata[1:0]);
        end
    end

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    assign left_dec   = bytes_left_reg - 17'd1;
    assign hdr_sum    = bytes_left_reg + {9'd0, data_byte};
    assign hdr_padded = (hdr_sum + PAD_ADD) & PAD_MASK;
    assign prefix_len = {header_word_reg[7:0], data_byte};

    always_comb
    begin
        header_word_next  = header_word_reg;
        header_count_next = header_count_reg;
        bytes_left_next   = bytes_left_reg;
        in_body_next      = in_body_reg;
        res_valid         = 1'b0;
        res_first         = 1'b0;
        res_last          = 1'b0;

        if (frame_mode_reg == MODE_RSVD)
        begin
            res_valid = 1'b0;
        end
        else if (in_body_reg)
        begin
            res_valid        = 1'b1;
            res_first        = (bytes_left_reg == {1'b0, header_word_reg});
            header_word_next = '0;
            bytes_left_next  = left_dec;
            res_last         = (left_dec == '0);
            if (res_last)
            begin
                in_body_next = 1'b0;
            end
        end
        else if (frame_mode_reg == MODE_PREFIX)
        begin
            if (header_count_reg == HC_0)
            begin
                header_word_next  = {8'd0, data_byte};
                header_count_next = HC_1;
            end
            else
            begin
                header_count_next = HC_0;
                if (prefix_len == '0)
                begin
                    header_word_next = '0;
                end
                else
                begin
                    header_word_next = prefix_len;
                    bytes_left_next  = {1'b0, prefix_len};
                    in_body_next     = 1'b1;
                end
            end
        end
        else
        begin
            res_valid = 1'b1;
            unique case (header_count_reg)
                HC_0:
                begin
                    header_word_next  = {8'd0, data_byte};
                    header_count_next = HC_1;
                    res_first         = 1'b1;
                end
                HC_1:
                begin
                    header_word_next  = prefix_len;
                    header_count_next = HC_2;
                end
                HC_2:
                begin
                    bytes_left_next   = ((header_word_reg < STUN_LIMIT) ? STUN_BASE : CD_BASE)
                                        + {1'b0, data_byte, 8'd0};
                    header_count_next = HC_3;
                end
                HC_3:
                begin
                    header_count_next = HC_0;
                    header_word_next  = '0;
                    if (hdr_padded <= HDR_BYTES)
                    begin
                        bytes_left_next = '0;
                        res_last        = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = hdr_padded - HDR_BYTES;
                        in_body_next    = 1'b1;
                    end
                end
                default:
                begin
                    header_count_next = HC_0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_word_reg  <= '0;
            header_count_reg <= HC_0;
            bytes_left_reg   <= '0;
            in_body_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            header_word_reg  <= header_word_next;
            header_count_reg <= header_count_next;
            bytes_left_reg   <= bytes_left_next;
            in_body_reg      <= in_body_next;
        end
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire && res_valid)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_fire)
        begin
            out_byte_reg  <= skid_byte_reg;
            out_first_reg <= skid_first_reg;
            out_last_reg  <= skid_last_reg;
        end
        else if (in_fire && res_valid && !(out_valid_reg && !out_fire))
        begin
            out_byte_reg  <= data_byte;
            out_first_reg <= res_first;
            out_last_reg  <= res_last;
        end

        if (!skid_valid_reg && in_fire && res_valid && out_valid_reg && !out_fire)
        begin
            skid_byte_reg  <= data_byte;
            skid_first_reg <= res_first;
            skid_last_reg  <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign frame_first = out_first_reg;
    assign frame_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: src/ttsd_checker.sv
`default_nettype none

module ttsd_checker
    import ttsd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       frame_first,
    input wire logic       frame_last
);

    // held result must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(frame_first) && $stable(frame_last))
        else $error("result changed while stalled");

    // skid full implies a pending result
    a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    // skid fills only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
        else $error("input stall without a stalled output");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> !in_stall)
        else $error("input stalled after empty output");

endmodule

bind turn_tcp_stream_deframer_top ttsd_checker u_ttsd_checker (.*);

`default_nettype wire

FILE: tb/sv/turn_tcp_stream_deframer_top_tb.sv
`default_nettype none

module turn_tcp_stream_deframer_top_tb;
    import ttsd_pkg::*;

    localparam int HOLD_LEN    = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 4;

    localparam logic [15:0] CD_MIN_WORD  = 16'h4000;
    localparam logic [16:0] STUN_HDR_LEN = 17'd20;
    localparam logic [16:0] CD_HDR_LEN   = 17'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } deframed_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         out_byte;
    logic               frame_first;
    logic               frame_last;

    turn_tcp_stream_deframer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .frame_first (frame_first),
        .frame_last  (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0] stream_q [$];
    deframed_t  deframed_q [$];
    deframed_t  want;

    int   tx_gap_pct   = 0;
    int   rx_stall_pct = 0;
    logic hold_req     = 1'b0;
    int   hold_cnt     = 0;
    int   quiet_cycles = 0;
    int   mismatches   = 0;

    // shadow of the deframer
    frame_mode_t mode_shadow = MODE_RFC5766;
    logic [15:0] hdr_word    = '0;
    logic [2:0]  hdr_cnt     = '0;
    logic [16:0] bytes_due   = '0;
    logic        in_body     = 1'b0;

    task automatic deframe_byte(input logic [7:0] b);
        logic [16:0] total;
        deframed_t   r;
        r.data  = b;
        r.first = 1'b0;
        r.last  = 1'b0;
        if (mode_shadow == MODE_RSVD)
            return;
        if (in_body)
        begin
            r.first   = (bytes_due == {1'b0, hdr_word});
            hdr_word  = '0;
            bytes_due = bytes_due - 17'd1;
            r.last    = (bytes_due == '0);
            in_body   = !r.last;
            deframed_q.push_back(r);
        end
        else if (mode_shadow == MODE_PREFIX)
        begin
            if (hdr_cnt == 3'd0)
            begin
                hdr_word = {8'd0, b};
                hdr_cnt  = 3'd1;
            end
            else
            begin
                hdr_word = {hdr_word[7:0], b};
                hdr_cnt  = 3'd0;
                if (hdr_word != '0)
                begin
                    bytes_due = {1'b0, hdr_word};
                    in_body   = 1'b1;
                end
            end
        end
        else
        begin
            case (hdr_cnt)
                3'd0:
                begin
                    hdr_word = {8'd0, b};
                    hdr_cnt  = 3'd1;
                    r.first  = 1'b1;
                end
                3'd1:
                begin
                    hdr_word = {hdr_word[7:0], b};
                    hdr_cnt  = 3'd2;
                end
                3'd2:
                begin
                    bytes_due = ((hdr_word < CD_MIN_WORD) ? STUN_HDR_LEN : CD_HDR_LEN)
                              + {1'b0, b, 8'd0};
                    hdr_cnt   = 3'd3;
                end
                default:
                begin
                    total    = bytes_due + {9'd0, b};
                    total    = (total + 17'd3) & ~17'd3;
                    hdr_cnt  = 3'd0;
                    hdr_word = '0;
                    if (total <= CD_HDR_LEN)
                    begin
                        bytes_due = '0;
                        r.last    = 1'b1;
                    end
                    else
                    begin
                        bytes_due = total - CD_HDR_LEN;
                        in_body   = 1'b1;
                    end
                end
            endcase
            deframed_q.push_back(r);
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                deframe_byte(data_byte);
            if (!in_valid || !in_stall)
            begin
                if (stream_q.size() != 0 && $urandom_range(99) >= tx_gap_pct)
                begin
                    in_valid  <= 1'b1;
                    data_byte <= stream_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (hold_req && hold_cnt < HOLD_LEN)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
            if (!hold_req)
                hold_cnt <= 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (deframed_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, got byte %h first %b last %b",
                         $time, out_byte, frame_first, frame_last);
                mismatches++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %h got %h", $time, want.data, out_byte);
                    mismatches++;
                end
                if (frame_first !== want.first)
                begin
                    $display("%0t: frame_first expected %b got %b", $time, want.first,
                             frame_first);
                    mismatches++;
                end
                if (frame_last !== want.last)
                begin
                    $display("%0t: frame_last expected %b got %b", $time, want.last, frame_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic wait_idle();
        forever
        begin
            while (stream_q.size() != 0 || in_valid || deframed_q.size() != 0)
                @(posedge clk);
            repeat (TAIL_CYCLES) @(posedge clk);
            if (stream_q.size() == 0 && !in_valid && deframed_q.size() == 0)
                break;
        end
    endtask

    task automatic write_mode(input frame_mode_t m);
        logic [PDATA_W-1:0] w;
        wait_idle();
        w      = $urandom();
        w[1:0] = m;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_FRAME_MODE;
        pwdata  <= w;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_shadow = m;
    endtask

    task automatic push_frame4(input logic [15:0] word, input logic [15:0] len);
        int total;
        total = ((word < CD_MIN_WORD) ? 20 : 4) + int'(len);
        total = (total + 3) / 4 * 4;
        stream_q = {stream_q, word[15:8], word[7:0], len[15:8], len[7:0]};
        repeat (total - 4) stream_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic push_frame2(input logic [15:0] len);
        stream_q = {stream_q, len[15:8], len[7:0]};
        repeat (int'(len)) stream_q.push_back(8'($urandom_range(255)));
    endtask

    // well-formed frames with random content; stray bytes in the reserved mode
    task automatic push_random(input frame_mode_t m, input int n_items);
        int          stop_at;
        logic [15:0] len;
        logic [15:0] word;
        stop_at = stream_q.size() + n_items;
        while (stream_q.size() < stop_at)
        begin
            len = ($urandom_range(7) == 0) ? 16'($urandom_range(300)) : 16'($urandom_range(40));
            if (m == MODE_RSVD)
                repeat ($urandom_range(3, 1)) stream_q.push_back(8'($urandom_range(255)));
            else if (m == MODE_PREFIX)
                push_frame2(($urandom_range(11) == 0) ? 16'h0000 : len);
            else
            begin
                word = $urandom_range(1) ? 16'($urandom_range(16'h3FFF))
                                         : 16'($urandom_range(16'hFFFF, 16'h4000));
                push_frame4(word, len);
            end
        end
    endtask

    // run the stream up to a frame boundary
    task automatic align_stream();
        while (in_body || hdr_cnt != 3'd0)
        begin
            repeat (in_body ? int'(bytes_due) : 1) stream_q.push_back(8'($urandom_range(255)));
            wait_idle();
        end
    endtask

    initial
    begin
        frame_mode_t phase_modes [4];
        phase_modes = '{MODE_RFC5766, MODE_PREFIX, MODE_RSVD, MODE_DRAFT9};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header-only channel data, then padded channel data with an all-ones header
        push_frame4(16'h4000, 16'h0000);
        push_frame4(16'hFFFF, 16'h0001);
        // leave three header bytes pending, finish them as a two-byte prefix
        write_mode(MODE_DRAFT9);
        stream_q = {stream_q, 8'h40, 8'h00, 8'h00};
        write_mode(MODE_PREFIX);
        stream_q = {stream_q, 8'h02, 8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
        write_mode(MODE_RSVD);
        stream_q = {stream_q, 8'h12, 8'hED};

        for (int s = 0; s < 3; s++)
        begin
            case (s)
                0:
                begin
                    tx_gap_pct   = 23;
                    rx_stall_pct = 60;
                end
                1:
                begin
                    tx_gap_pct   = 60;
                    rx_stall_pct = 23;
                end
                default:
                begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
            endcase
            foreach (phase_modes[k])
            begin
                write_mode(phase_modes[k]);
                if (phase_modes[k] != MODE_RSVD && $urandom_range(1))
                    align_stream();
                if (s == 2 && k == 0)
                begin
                    hold_req <= 1'b1;
                    push_random(phase_modes[k], 72);
                    while (hold_cnt < HOLD_LEN)
                        @(posedge clk);
                    hold_req <= 1'b0;
                end
                else
                    push_random(phase_modes[k], (phase_modes[k] == MODE_RSVD) ? 6 : 72);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
